/* rtl/core/zdss_pkg.sv */
// Shared types and constants for the zero-delimited string search block.
`default_nettype none

package zdss_pkg;

    // Sizes of the pattern store and the progress vector
    localparam int PATTERN_MAX = 256;
    localparam int PAT_AW      = $clog2(PATTERN_MAX);
    localparam int PROG_W      = PATTERN_MAX + 1;
    localparam int SAT_W       = $clog2(PATTERN_MAX + 1);

    // Field widths fixed by the interface
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 8;
    localparam int CFG_W       = 9;
    localparam int POS_W       = 23;
    localparam int MASK_ROWS   = 1 << BYTE_W;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TEXT = 1'b1
    } opcode_e;

    // One bit write into the character mask memory
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [BYTE_W-1:0] row;
        logic [PAT_AW-1:0] col;
    } mask_wr_t;

endpackage

`default_nettype wire

/* rtl/core/zero_delimited_string_search.sv */
// Top level of the zero-delimited string search block.
`default_nettype none

// Finds the first occurrence of a stored pattern that has a zero byte right
// before and right after it in a stream of text bytes. The byte before the
// first text byte and after the byte flagged last count as zero. Load
// requests (opcode 0) write one pattern byte; text requests (opcode 1) feed
// one text byte; the text byte flagged last produces one result (found plus
// start offset of the first match, 0 when none) and resets the stream, the
// pattern is kept. cfg_pattern_length sets the pattern length, saturated to
// 256; zero never matches. Text requests are taken one per clock unless stalled:
// the byte reads its row of a 256 x 256 character mask memory, and then a
// shift-and progress vector advances by that row. The result is written to an
// output register when the last byte advances the progress vector, so further
// requests keep flowing while it waits; only a second last byte stalls until
// the first result is taken. A load request holds off the request after it:
// the mask memory has one write port, and the load sets the bit of the new
// byte on accept and clears the bit of the byte it replaces in the next cycle.
// Mask rows carry valid flags cleared by reset, so no clearing pass is
// needed after reset. Reading pattern positions never loaded gives
// unspecified results. The user must write configuration only while no
// request is in flight; the block itself does not enforce this.
module zero_delimited_string_search (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [zdss_pkg::CFG_W-1:0]         cfg_pattern_length,
    // request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_opcode,
    input  wire logic [zdss_pkg::IDX_W-1:0]         s_pattern_index,
    input  wire logic [zdss_pkg::BYTE_W-1:0]        s_byte_value,
    input  wire logic                               s_last_byte,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_found,
    output logic      [zdss_pkg::POS_W-1:0]         m_match_offset
);

    logic                          acc;
    logic                          text_acc;
    logic                          load_acc;
    logic                          s1_go;
    logic [zdss_pkg::PAT_AW-1:0]   pat_addr;
    logic [zdss_pkg::BYTE_W-1:0]   old_byte;
    logic                          clr_pending_reg;
    logic [zdss_pkg::PAT_AW-1:0]   clr_col_reg;
    logic [zdss_pkg::BYTE_W-1:0]   new_row_reg;
    logic [zdss_pkg::PATTERN_MAX-1:0] mask_row;
    zdss_pkg::mask_wr_t            mask_wr;

    assign cfg_ready = 1'b1;

    // hold requests off while a load finishes its clear write or the scan stage is stalled
    assign s_ready  = !clr_pending_reg && s1_go;
    assign acc      = s_valid && s_ready;
    assign text_acc = acc && (s_opcode == zdss_pkg::OP_TEXT);
    // loads beyond the store are dropped
    assign load_acc = acc && (s_opcode == zdss_pkg::OP_LOAD)
                      && (32'(s_pattern_index) < zdss_pkg::PATTERN_MAX);
    assign pat_addr = zdss_pkg::PAT_AW'(s_pattern_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_pending_reg <= 1'b0;
        end else begin
            clr_pending_reg <= load_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_acc) begin
            clr_col_reg <= pat_addr;
            new_row_reg <= s_byte_value;
        end
    end

    // set the new byte's bit on accept, clear the replaced byte's bit in the next cycle
    always_comb begin
        mask_wr.set = load_acc;
        mask_wr.clr = clr_pending_reg && (old_byte != new_row_reg);
        if (clr_pending_reg) begin
            mask_wr.row = old_byte;
            mask_wr.col = clr_col_reg;
        end else begin
            mask_wr.row = s_byte_value;
            mask_wr.col = pat_addr;
        end
    end

    zdss_pattern_ram u_pattern_ram (
        .aclk     (aclk),
        .wr_en    (load_acc),
        .addr     (pat_addr),
        .wr_data  (s_byte_value),
        .old_data (old_byte)
    );

    zdss_mask_ram u_mask_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (text_acc),
        .rd_row  (s_byte_value),
        .wr      (mask_wr),
        .rd_data (mask_row)
    );

    zdss_scan u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_len        (cfg_pattern_length),
        .text_acc       (text_acc),
        .text_byte      (s_byte_value),
        .text_last      (s_last_byte),
        .mask_row       (mask_row),
        .s1_go          (s1_go),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_match_offset (m_match_offset)
    );

`ifndef SYNTHESIS
    // every in-range load is followed by its clear cycle, in which no request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_acc |=> clr_pending_reg && !acc)
        else $error("load not followed by its clear cycle");
    // clear cycle targets the column of the load, and never coincides with a set
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_pending_reg |-> !mask_wr.set && mask_wr.col == $past(pat_addr))
        else $error("clear write mistargeted");
`endif

endmodule

`default_nettype wire

/* rtl/core/zdss_pattern_ram.sv */
// Pattern byte store: one port, read of the old byte while the new one is written.
`default_nettype none

module zdss_pattern_ram (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [zdss_pkg::PAT_AW-1:0]      addr,
    input  wire logic [zdss_pkg::BYTE_W-1:0]      wr_data,
    output logic      [zdss_pkg::BYTE_W-1:0]      old_data
);

    logic [zdss_pkg::BYTE_W-1:0] mem [zdss_pkg::PATTERN_MAX];
    logic [zdss_pkg::BYTE_W-1:0] old_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            old_data_reg <= mem[addr];
            mem[addr]    <= wr_data;
        end
    end

    assign old_data = old_data_reg;

endmodule

`default_nettype wire

/* rtl/core/zdss_mask_ram.sv */
// Character mask memory: one row per byte value, one bit per pattern position.
`default_nettype none

module zdss_mask_ram (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  rd_en,
    input  wire logic [zdss_pkg::BYTE_W-1:0]           rd_row,
    input  wire zdss_pkg::mask_wr_t                    wr,
    output logic      [zdss_pkg::PATTERN_MAX-1:0]      rd_data
);

    logic [zdss_pkg::PATTERN_MAX-1:0] mem [zdss_pkg::MASK_ROWS];
    logic [zdss_pkg::MASK_ROWS-1:0]   row_vld_reg;
    logic [zdss_pkg::PATTERN_MAX-1:0] rd_data_reg;
    logic                             rd_vld_reg;

    // A row never written reads as all zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr.set) begin
                row_vld_reg[wr.row] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= row_vld_reg[rd_row];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.set) begin
            if (row_vld_reg[wr.row]) begin
                mem[wr.row][wr.col] <= 1'b1;
            end else begin
                mem[wr.row] <= zdss_pkg::PATTERN_MAX'(1) << wr.col;
            end
        end else if (wr.clr && row_vld_reg[wr.row]) begin
            mem[wr.row][wr.col] <= 1'b0;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

`ifndef SYNTHESIS
    // both writes share one port, so they must never coincide
    assert property (@(posedge aclk) disable iff (!aresetn) !(wr.set && wr.clr))
        else $error("mask set and clear in the same cycle");
`endif

endmodule

`default_nettype wire

/* rtl/core/zdss_scan.sv */
// Progress vector, match tracking and result register for the text stream.
`default_nettype none

module zdss_scan (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [zdss_pkg::CFG_W-1:0]            cfg_len,
    input  wire logic                                  text_acc,
    input  wire logic [zdss_pkg::BYTE_W-1:0]           text_byte,
    input  wire logic                                  text_last,
    input  wire logic [zdss_pkg::PATTERN_MAX-1:0]      mask_row,
    output logic                                       s1_go,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_found,
    output logic      [zdss_pkg::POS_W-1:0]            m_match_offset
);

    logic [zdss_pkg::SAT_W-1:0]   len_reg, len_next;
    logic [zdss_pkg::PROG_W-1:0]  lenmask_reg, lenmask_next;
    logic [zdss_pkg::PROG_W-1:0]  prog_reg, prog_adv;
    logic [zdss_pkg::POS_W-1:0]   pos_reg;
    logic                         seen_reg, seen_next;
    logic [zdss_pkg::POS_W-1:0]   first_reg, first_next;
    logic                         s1_valid_reg;
    logic [zdss_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                         s1_last_reg;
    logic                         m_valid_reg;
    logic                         m_found_reg;
    logic [zdss_pkg::POS_W-1:0]   m_offset_reg;
    logic                         advance;
    logic                         hit_close, hit_end;
    logic [zdss_pkg::POS_W-1:0]   start_close, start_end;

    // Saturated length and its thermometer mask
    always_comb begin
        if (32'(cfg_len) > zdss_pkg::PATTERN_MAX) begin
            len_next = zdss_pkg::SAT_W'(zdss_pkg::PATTERN_MAX);
        end else begin
            len_next = zdss_pkg::SAT_W'(cfg_len);
        end
        for (int k = 0; k < zdss_pkg::PROG_W; k++) begin
            lenmask_next[k] = (k <= 32'(len_next));
        end
    end

    assign s1_go   = !(s1_valid_reg && s1_last_reg && m_valid_reg && !m_ready);
    assign advance = s1_valid_reg && s1_go;

    always_comb begin
        start_close = pos_reg - zdss_pkg::POS_W'(len_reg);
        start_end   = start_close + zdss_pkg::POS_W'(1);
        hit_close   = (len_reg != '0) && prog_reg[len_reg] && (s1_byte_reg == '0);
        prog_adv    = {prog_reg[zdss_pkg::PATTERN_MAX-1:0] & mask_row, s1_byte_reg == '0}
                      & lenmask_reg;
        hit_end     = s1_last_reg && (len_reg != '0) && prog_adv[len_reg];
        seen_next   = seen_reg;
        first_next  = first_reg;
        // earliest start wins: a candidate closed by this byte precedes one ending here
        priority if (seen_reg) begin
            seen_next = seen_reg;
        end else if (hit_close) begin
            seen_next  = 1'b1;
            first_next = start_close;
        end else if (hit_end) begin
            seen_next  = 1'b1;
            first_next = start_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            lenmask_reg  <= zdss_pkg::PROG_W'(1);
            prog_reg     <= zdss_pkg::PROG_W'(1);
            pos_reg      <= '0;
            seen_reg     <= 1'b0;
            first_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                len_reg     <= len_next;
                lenmask_reg <= lenmask_next;
            end
            if (text_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (s1_last_reg) begin
                    prog_reg  <= zdss_pkg::PROG_W'(1);
                    pos_reg   <= '0;
                    seen_reg  <= 1'b0;
                    first_reg <= '0;
                end else begin
                    prog_reg  <= prog_adv;
                    pos_reg   <= pos_reg + zdss_pkg::POS_W'(1);
                    seen_reg  <= seen_next;
                    first_reg <= first_next;
                end
            end
            if (advance && s1_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (text_acc) begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= text_last;
        end
        if (advance && s1_last_reg) begin
            m_found_reg  <= seen_next;
            m_offset_reg <= seen_next ? first_next : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_match_offset = m_offset_reg;

`ifndef SYNTHESIS
    // a finished buffer leaves a fresh stream behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && s1_last_reg |=> prog_reg == zdss_pkg::PROG_W'(1) && pos_reg == '0
                                   && !seen_reg)
        else $error("stream state not cleared after last byte");
    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && s1_last_reg && m_valid_reg |-> m_ready)
        else $error("result register overwritten");
    // no new text byte enters while the stage ahead is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        text_acc |-> !s1_valid_reg || s1_go)
        else $error("text accepted over a stalled stage");
`endif

endmodule

`default_nettype wire
